[hw/rtl/imhdk_pkg.sv]
// Package with the types, constants and state codes of the indexed min-heap core.
`timescale 1ns / 1ps
package imhdk_pkg;

    // Heap capacity and derived widths.
    localparam int NODE_COUNT = 1024;
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    localparam int POS_W      = ADDR_W + 1;
    localparam int NODE_W     = 10;
    localparam int DIST_W     = 31;
    localparam int INFO_W     = DIST_W + NODE_W;

    // Operation codes.
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_DEC   = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DUP       = 3'd3;
    localparam logic [2:0] ST_NOT_IN    = 3'd4;
    localparam logic [2:0] ST_NOT_SMALL = 3'd5;
    localparam logic [2:0] ST_UNKNOWN   = 3'd6;

    // Input transaction.
    typedef struct packed {
        logic [1:0]        mode;
        logic [NODE_W-1:0] node_id;
        logic [DIST_W-1:0] distance;
        logic [NODE_W-1:0] predecessor;
    } t_in;

    // Result transaction.
    typedef struct packed {
        logic [NODE_W-1:0] out_node;
        logic [DIST_W-1:0] out_distance;
        logic [NODE_W-1:0] out_predecessor;
        logic [10:0]       out_position;
        logic [10:0]       heap_size;
        logic [2:0]        status;
    } t_out;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_POP1, S_POP2,
        S_DN0, S_DN1, S_DN2, S_DN3, S_CLRN,
        S_UP0, S_UP1, S_UP2, S_DONE
    } t_state;

endpackage

[hw/rtl/imhdk_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module imhdk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hw/rtl/indexed_min_heap_decrease_key_core.sv]
// Indexed binary min-heap with decrease-key, built around three synchronous RAMs.
//
// Input channel: i_valid / o_stall carry one operation (push, pop minimum,
// decrease key, query) per transaction. Output channel: o_valid / i_stall
// carry exactly one result per accepted operation, in order.
// Operations are handled one at a time. A query or any rejected operation
// goes from the lookup state straight to the result. A push or decrease key
// moves the entry up one level per compare step, and a pop moves the entry
// taken from the last slot down one level per step until it settles
// (up to 10 levels at 1024 nodes).
// The slot and node RAMs have registered read data, so each level needs a
// slot read followed by a dependent distance read.
// After reset the position RAM is swept clear, one entry per cycle, over all
// NODE_COUNT (1024) entries; o_stall stays high during that sweep.
// A finished result sits in an output register; while the receiver stalls,
// the next operation may still be accepted and run, and its completion waits
// until the held result has been taken.
`timescale 1ns / 1ps
module indexed_min_heap_decrease_key_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  imhdk_pkg::t_in i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output imhdk_pkg::t_out o_out
);
    import imhdk_pkg::*;

    // Registers.
    t_state            r_state, n_state;
    logic [POS_W-1:0]  r_count, n_count;
    logic [1:0]        r_mode, n_mode;
    logic [NODE_W-1:0] r_id, n_id;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic [NODE_W-1:0] r_pred, n_pred;
    logic [NODE_W-1:0] r_mnode, n_mnode;
    logic [DIST_W-1:0] r_mkey, n_mkey;
    logic [POS_W-1:0]  r_p, n_p;
    logic [NODE_W-1:0] r_n, n_n;
    logic [NODE_W-1:0] r_a, n_a;
    logic [DIST_W-1:0] r_ka, n_ka;
    logic [NODE_W-1:0] r_b, n_b;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [NODE_W-1:0] r_rnode, n_rnode;
    logic [DIST_W-1:0] r_rdist, n_rdist;
    logic [NODE_W-1:0] r_rpred, n_rpred;
    logic [POS_W-1:0]  r_rpos, n_rpos;
    logic [2:0]        r_rst, n_rst;
    t_out              r_out, n_out;
    logic              r_out_valid, n_out_valid;

    // Memory ports.
    logic              heap_we, info_we, pos_we;
    logic [ADDR_W-1:0] heap_waddr, heap_raddr, info_waddr, info_raddr, pos_waddr, pos_raddr;
    logic [NODE_W-1:0] heap_wdata, heap_rdata;
    logic [INFO_W-1:0] info_wdata, info_rdata;
    logic [POS_W:0]    pos_wdata, pos_rdata;

    // Helper values.
    logic [POS_W:0]    l_pos, r_pos_c, count_x;
    logic              bestl, bestr;
    logic [DIST_W-1:0] best_key;

    assign l_pos   = {r_p, 1'b0};
    assign r_pos_c = l_pos + (POS_W+1)'(1);
    assign count_x = {1'b0, r_count};

    // Slot to node map.
    imhdk_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_heap (
        .i_clk(i_clk), .i_we(heap_we), .i_waddr(heap_waddr), .i_wdata(heap_wdata),
        .i_raddr(heap_raddr), .o_rdata(heap_rdata)
    );

    // Per-node distance and predecessor.
    imhdk_ram #(.WIDTH(INFO_W), .DEPTH(NODE_COUNT)) u_info (
        .i_clk(i_clk), .i_we(info_we), .i_waddr(info_waddr), .i_wdata(info_wdata),
        .i_raddr(info_raddr), .o_rdata(info_rdata)
    );

    // Per-node known flag and heap position.
    imhdk_ram #(.WIDTH(POS_W+1), .DEPTH(NODE_COUNT)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_raddr(pos_raddr), .o_rdata(pos_rdata)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // State register and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_mode  <= n_mode;
        r_id    <= n_id;
        r_dist  <= n_dist;
        r_pred  <= n_pred;
        r_mnode <= n_mnode;
        r_mkey  <= n_mkey;
        r_p     <= n_p;
        r_n     <= n_n;
        r_a     <= n_a;
        r_ka    <= n_ka;
        r_b     <= n_b;
        r_rnode <= n_rnode;
        r_rdist <= n_rdist;
        r_rpred <= n_rpred;
        r_rpos  <= n_rpos;
        r_rst   <= n_rst;
        r_out   <= n_out;
    end

    // Sequencer: next state, memory controls and register updates.
    always_comb begin
        n_state = r_state;  n_count = r_count;  n_mode = r_mode;  n_id = r_id;
        n_dist = r_dist;    n_pred = r_pred;    n_mnode = r_mnode; n_mkey = r_mkey;
        n_p = r_p;          n_n = r_n;          n_a = r_a;        n_ka = r_ka;
        n_b = r_b;          n_clr = r_clr;      n_rnode = r_rnode; n_rdist = r_rdist;
        n_rpred = r_rpred;  n_rpos = r_rpos;    n_rst = r_rst;    n_out = r_out;
        n_out_valid = r_out_valid && i_stall;
        heap_we = 1'b0; heap_waddr = '0; heap_wdata = '0; heap_raddr = '0;
        info_we = 1'b0; info_waddr = '0; info_wdata = '0; info_raddr = '0;
        pos_we  = 1'b0; pos_waddr  = '0; pos_wdata  = '0; pos_raddr  = '0;
        bestl    = (r_ka < r_mkey);
        best_key = bestl ? r_ka : r_mkey;
        bestr    = (r_pos_c <= count_x) && (info_rdata[INFO_W-1:NODE_W] < best_key);

        unique case (r_state)
            S_CLEAR: begin
                pos_we    = 1'b1;
                pos_waddr = r_clr;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                pos_raddr  = i_in.node_id[ADDR_W-1:0];
                info_raddr = i_in.node_id[ADDR_W-1:0];
                heap_raddr = '0;
                if (i_valid) begin
                    n_mode = i_in.mode;  n_id = i_in.node_id;
                    n_dist = i_in.distance; n_pred = i_in.predecessor;
                    n_rnode = '0; n_rdist = '0; n_rpred = '0; n_rpos = '0; n_rst = ST_OK;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_DONE;
                if (r_mode == MODE_POP) begin
                    if (r_count == '0) begin
                        n_rst = ST_EMPTY;
                    end else begin
                        n_n        = heap_rdata;
                        heap_raddr = ADDR_W'(r_count - POS_W'(1));
                        info_raddr = heap_rdata[ADDR_W-1:0];
                        n_state    = S_POP1;
                    end
                end else if ({1'b0, r_id} >= (NODE_W+1)'(NODE_COUNT)) begin
                    n_rst = ST_UNKNOWN;
                end else if (r_mode == MODE_PUSH) begin
                    if (pos_rdata[POS_W-1:0] != '0) begin
                        n_rst = ST_DUP;
                    end else if (r_count >= POS_W'(NODE_COUNT)) begin
                        n_rst = ST_FULL;
                    end else begin
                        n_count    = r_count + POS_W'(1);
                        info_we    = 1'b1;
                        info_waddr = r_id[ADDR_W-1:0];
                        info_wdata = {r_dist, r_pred};
                        n_mnode = r_id; n_mkey = r_dist; n_p = r_count + POS_W'(1);
                        n_rnode = r_id; n_rdist = r_dist; n_rpred = r_pred;
                        n_state = S_UP0;
                    end
                end else if (!pos_rdata[POS_W]) begin
                    n_rst = ST_UNKNOWN;
                end else if (r_mode == MODE_DEC) begin
                    if (pos_rdata[POS_W-1:0] == '0) begin
                        n_rst = ST_NOT_IN;
                    end else if (!(r_dist < info_rdata[INFO_W-1:NODE_W])) begin
                        n_rst   = ST_NOT_SMALL;
                        n_rnode = r_id;
                        n_rdist = info_rdata[INFO_W-1:NODE_W];
                        n_rpred = info_rdata[NODE_W-1:0];
                        n_rpos  = pos_rdata[POS_W-1:0];
                    end else begin
                        info_we    = 1'b1;
                        info_waddr = r_id[ADDR_W-1:0];
                        info_wdata = {r_dist, r_pred};
                        n_mnode = r_id; n_mkey = r_dist; n_p = pos_rdata[POS_W-1:0];
                        n_rnode = r_id; n_rdist = r_dist; n_rpred = r_pred;
                        n_state = S_UP0;
                    end
                end else begin
                    n_rnode = r_id;
                    n_rdist = info_rdata[INFO_W-1:NODE_W];
                    n_rpred = info_rdata[NODE_W-1:0];
                    n_rpos  = pos_rdata[POS_W-1:0];
                end
            end
            S_POP1: begin
                n_rnode    = r_n;
                n_rdist    = info_rdata[INFO_W-1:NODE_W];
                n_rpred    = info_rdata[NODE_W-1:0];
                n_mnode    = heap_rdata;
                info_raddr = heap_rdata[ADDR_W-1:0];
                n_state    = S_POP2;
            end
            S_POP2: begin
                n_mkey  = info_rdata[INFO_W-1:NODE_W];
                n_count = r_count - POS_W'(1);
                n_p     = POS_W'(1);
                n_state = (r_count == POS_W'(1)) ? S_CLRN : S_DN0;
            end
            S_DN0: begin
                // Place the moving entry when the hole has no child.
                if (l_pos > count_x) begin
                    heap_we    = 1'b1;
                    heap_waddr = ADDR_W'(r_p - POS_W'(1));
                    heap_wdata = r_mnode;
                    pos_we     = 1'b1;
                    pos_waddr  = r_mnode[ADDR_W-1:0];
                    pos_wdata  = {1'b1, r_p};
                    n_state    = S_CLRN;
                end else begin
                    heap_raddr = ADDR_W'(l_pos - (POS_W+1)'(1));
                    n_state    = S_DN1;
                end
            end
            S_DN1: begin
                n_a        = heap_rdata;
                info_raddr = heap_rdata[ADDR_W-1:0];
                heap_raddr = ADDR_W'(l_pos);
                n_state    = S_DN2;
            end
            S_DN2: begin
                n_ka       = info_rdata[INFO_W-1:NODE_W];
                n_b        = heap_rdata;
                info_raddr = heap_rdata[ADDR_W-1:0];
                n_state    = S_DN3;
            end
            S_DN3: begin
                // Move the smaller child up into the hole, or settle here.
                heap_we    = 1'b1;
                heap_waddr = ADDR_W'(r_p - POS_W'(1));
                pos_we     = 1'b1;
                pos_wdata  = {1'b1, r_p};
                if (bestr) begin
                    heap_wdata = r_b;
                    pos_waddr  = r_b[ADDR_W-1:0];
                    n_p        = POS_W'(r_pos_c);
                    n_state    = S_DN0;
                end else if (bestl) begin
                    heap_wdata = r_a;
                    pos_waddr  = r_a[ADDR_W-1:0];
                    n_p        = POS_W'(l_pos);
                    n_state    = S_DN0;
                end else begin
                    heap_wdata = r_mnode;
                    pos_waddr  = r_mnode[ADDR_W-1:0];
                    n_state    = S_CLRN;
                end
            end
            S_CLRN: begin
                // The popped node stays known but leaves the heap.
                pos_we    = 1'b1;
                pos_waddr = r_n[ADDR_W-1:0];
                pos_wdata = {1'b1, POS_W'(0)};
                n_rpos    = '0;
                n_state   = S_DONE;
            end
            S_UP0: begin
                if (r_p == POS_W'(1)) begin
                    heap_we    = 1'b1;
                    heap_waddr = '0;
                    heap_wdata = r_mnode;
                    pos_we     = 1'b1;
                    pos_waddr  = r_mnode[ADDR_W-1:0];
                    pos_wdata  = {1'b1, r_p};
                    n_rpos     = r_p;
                    n_state    = S_DONE;
                end else begin
                    heap_raddr = ADDR_W'((r_p >> 1) - POS_W'(1));
                    n_state    = S_UP1;
                end
            end
            S_UP1: begin
                n_a        = heap_rdata;
                info_raddr = heap_rdata[ADDR_W-1:0];
                n_state    = S_UP2;
            end
            S_UP2: begin
                // Pull the parent down, or settle the moving entry here.
                heap_we    = 1'b1;
                heap_waddr = ADDR_W'(r_p - POS_W'(1));
                pos_we     = 1'b1;
                pos_wdata  = {1'b1, r_p};
                if (r_mkey < info_rdata[INFO_W-1:NODE_W]) begin
                    heap_wdata = r_a;
                    pos_waddr  = r_a[ADDR_W-1:0];
                    n_p        = r_p >> 1;
                    n_state    = S_UP0;
                end else begin
                    heap_wdata = r_mnode;
                    pos_waddr  = r_mnode[ADDR_W-1:0];
                    n_rpos     = r_p;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.out_node        = r_rnode;
                    n_out.out_distance    = r_rdist;
                    n_out.out_predecessor = r_rpred;
                    n_out.out_position    = 11'(r_rpos);
                    n_out.heap_size       = 11'(r_count);
                    n_out.status          = r_rst;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The entry count never exceeds the capacity.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= POS_W'(NODE_COUNT))
        else $error("heap count above capacity");

    // Slot writes stay inside the occupied part of the heap.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        heap_we |-> ({1'b0, heap_waddr} < r_count))
        else $error("slot write beyond heap end");

    // Sifting positions are nonzero and within the heap.
    a_hole_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP0 || r_state == S_DN0) |-> (r_p != '0 && r_p <= r_count))
        else $error("sift position out of range");

    // The clearing sweep touches no other memory and produces no result.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!heap_we && !info_we && !n_out_valid))
        else $error("activity during clearing sweep");

endmodule

[verif/indexed_min_heap_decrease_key_core_tb.sv]
// Self-checking testbench for the indexed min-heap decrease-key core.
`timescale 1ns / 1ps
module indexed_min_heap_decrease_key_core_tb;
    import imhdk_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_in = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_out;

    // Predicted heap state.
    logic [NODE_W-1:0] heap_order [NODE_COUNT];
    logic [DIST_W-1:0] dist_mem [NODE_COUNT];
    logic [NODE_W-1:0] pred_mem [NODE_COUNT];
    logic [10:0]       pos_mem [NODE_COUNT];
    bit                seen_mem [NODE_COUNT];
    int unsigned       entry_count;

    t_in  op_queue [$];
    t_out result_queue [$];
    int   mismatch_count = 0;
    bit   stim_done = 1'b0;
    bit   hold_off = 1'b0;
    int   send_wait = 0;
    int   recv_wait = 0;
    int   quiet_cycles = 0;

    indexed_min_heap_decrease_key_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_in(i_in), .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [DIST_W-1:0] key_of(int unsigned slot);
        return dist_mem[heap_order[slot-1]];
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [NODE_W-1:0] t;
        t = heap_order[a-1];
        heap_order[a-1] = heap_order[b-1];
        heap_order[b-1] = t;
        pos_mem[heap_order[a-1]] = a[10:0];
        pos_mem[heap_order[b-1]] = b[10:0];
    endfunction

    function automatic void sift_up(int unsigned slot);
        while (slot > 1 && key_of(slot) < key_of(slot >> 1)) begin
            swap_slots(slot, slot >> 1);
            slot = slot >> 1;
        end
    endfunction

    function automatic void sift_down(int unsigned slot);
        int unsigned l;
        int unsigned best;
        forever begin
            l = slot << 1;
            best = slot;
            if (l <= entry_count && key_of(l) < key_of(best)) best = l;
            if (l + 1 <= entry_count && key_of(l + 1) < key_of(best)) best = l + 1;
            if (best == slot) break;
            swap_slots(slot, best);
            slot = best;
        end
    endfunction

    // Apply one operation to the predicted heap and return its result.
    function automatic t_out heap_apply(t_in op);
        t_out r;
        logic [NODE_W-1:0] n;
        r = '0;
        n = op.node_id;
        if (op.mode == MODE_POP) begin
            if (entry_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                n = heap_order[0];
                swap_slots(1, entry_count);
                entry_count--;
                sift_down(1);
                pos_mem[n] = '0;
                r.out_node = n;
                r.out_distance = dist_mem[n];
                r.out_predecessor = pred_mem[n];
            end
        end else if (op.mode == MODE_PUSH) begin
            if (pos_mem[n] != 0) begin
                r.status = ST_DUP;
            end else if (entry_count >= NODE_COUNT) begin
                r.status = ST_FULL;
            end else begin
                entry_count++;
                heap_order[entry_count-1] = n;
                pos_mem[n] = entry_count[10:0];
                dist_mem[n] = op.distance;
                pred_mem[n] = op.predecessor;
                seen_mem[n] = 1'b1;
                sift_up(entry_count);
                r.out_node = n;
                r.out_distance = op.distance;
                r.out_predecessor = op.predecessor;
                r.out_position = pos_mem[n];
            end
        end else if (!seen_mem[n]) begin
            r.status = ST_UNKNOWN;
        end else if (op.mode == MODE_DEC && pos_mem[n] == 0) begin
            r.status = ST_NOT_IN;
        end else begin
            if (op.mode == MODE_DEC) begin
                if (op.distance < dist_mem[n]) begin
                    dist_mem[n] = op.distance;
                    pred_mem[n] = op.predecessor;
                    sift_up(pos_mem[n]);
                end else begin
                    r.status = ST_NOT_SMALL;
                end
            end
            r.out_node = n;
            r.out_distance = dist_mem[n];
            r.out_predecessor = pred_mem[n];
            r.out_position = pos_mem[n];
        end
        r.heap_size = entry_count[10:0];
        return r;
    endfunction

    function automatic t_in make_op(logic [1:0] m, int unsigned id, logic [DIST_W-1:0] d,
                                    int unsigned p);
        t_in op;
        op.mode = m;
        op.node_id = id[NODE_W-1:0];
        op.distance = d;
        op.predecessor = p[NODE_W-1:0];
        return op;
    endfunction

    function automatic logic [DIST_W-1:0] rand_dist();
        case ($urandom_range(0, 3))
            0: return DIST_W'($urandom_range(0, 15));
            1: return DIST_W'($urandom);
            2: return 31'h7FFF_FFFF - DIST_W'($urandom_range(0, 3));
            default: return DIST_W'($urandom_range(0, 1000));
        endcase
    endfunction

    // Stimulus: directed corner cases, a random mix, then a fill to capacity.
    initial begin
        int unsigned id_pool;
        int unsigned sel;
        op_queue.push_back(make_op(MODE_POP, 0, 0, 0));
        op_queue.push_back(make_op(MODE_QUERY, 5, 0, 0));
        op_queue.push_back(make_op(MODE_DEC, 5, 0, 0));
        op_queue.push_back(make_op(MODE_PUSH, 1023, 31'h7FFF_FFFF, 1023));
        op_queue.push_back(make_op(MODE_PUSH, 0, 31'h7FFF_FFFF, 0));
        op_queue.push_back(make_op(MODE_PUSH, 0, 3, 0));
        op_queue.push_back(make_op(MODE_PUSH, 7, 0, 512));
        op_queue.push_back(make_op(MODE_PUSH, 8, 0, 1));
        op_queue.push_back(make_op(MODE_DEC, 1023, 31'h7FFF_FFFF, 3));
        op_queue.push_back(make_op(MODE_DEC, 1023, 1, 3));
        op_queue.push_back(make_op(MODE_QUERY, 1023, 0, 0));
        op_queue.push_back(make_op(MODE_POP, 0, 0, 0));
        op_queue.push_back(make_op(MODE_QUERY, 7, 0, 0));
        op_queue.push_back(make_op(MODE_DEC, 7, 0, 0));
        op_queue.push_back(make_op(MODE_PUSH, 7, 9, 2));
        op_queue.push_back(make_op(MODE_POP, 0, 0, 0));
        op_queue.push_back(make_op(MODE_POP, 0, 0, 0));
        op_queue.push_back(make_op(MODE_POP, 0, 0, 0));
        op_queue.push_back(make_op(MODE_POP, 0, 0, 0));
        op_queue.push_back(make_op(MODE_POP, 0, 0, 0));
        // Random part: small node pool keeps duplicates and re-pushes frequent.
        for (int i = 0; i < 300; i++) begin
            id_pool = ($urandom_range(0, 4) == 0) ? 1023 : 63;
            sel = $urandom_range(0, 9);
            if (sel < 4)
                op_queue.push_back(make_op(MODE_PUSH, $urandom_range(0, id_pool),
                                           rand_dist(), $urandom_range(0, 1023)));
            else if (sel < 6)
                op_queue.push_back(make_op(MODE_POP, $urandom_range(0, 1023), rand_dist(),
                                           $urandom_range(0, 1023)));
            else if (sel < 8)
                op_queue.push_back(make_op(MODE_DEC, $urandom_range(0, id_pool),
                                           rand_dist(), $urandom_range(0, 1023)));
            else
                op_queue.push_back(make_op(MODE_QUERY, $urandom_range(0, id_pool),
                                           rand_dist(), $urandom_range(0, 1023)));
        end
        // Put every node into the heap, push once more at capacity, then pop part of it.
        for (int i = 0; i < NODE_COUNT; i++)
            op_queue.push_back(make_op(MODE_PUSH, i, DIST_W'($urandom_range(0, 63)), i));
        op_queue.push_back(make_op(MODE_PUSH, 5, 1, 1));
        for (int i = 0; i < 50; i++)
            op_queue.push_back(make_op(MODE_POP, 0, 0, 0));
    end

    // Reset sequence and state of the predicted heap.
    initial begin
        entry_count = 0;
        for (int i = 0; i < NODE_COUNT; i++) begin
            pos_mem[i] = '0;
            seen_mem[i] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: offers pending operations with random gaps.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                result_queue.push_back(heap_apply(i_in));
                send_wait = $urandom_range(0, 17);
                if ($urandom_range(0, 3) == 0) send_wait = 0;
            end
            if (!i_valid || !o_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    i_valid <= 1'b1;
                    i_in <= op_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                    stim_done = 1'b1;
                end
            end
        end
    end

    // Monitor: random stalls, one long hold-off, and result checks.
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (result_queue.size() == 0) begin
                    $error("unexpected result: %p", o_out);
                    mismatch_count++;
                end else begin
                    exp_r = result_queue.pop_front();
                    if (o_out.out_node !== exp_r.out_node) begin
                        $error("out_node exp %0d got %0d", exp_r.out_node, o_out.out_node);
                        mismatch_count++;
                    end
                    if (o_out.out_distance !== exp_r.out_distance) begin
                        $error("out_distance exp %0d got %0d", exp_r.out_distance,
                               o_out.out_distance);
                        mismatch_count++;
                    end
                    if (o_out.out_predecessor !== exp_r.out_predecessor) begin
                        $error("out_predecessor exp %0d got %0d", exp_r.out_predecessor,
                               o_out.out_predecessor);
                        mismatch_count++;
                    end
                    if (o_out.out_position !== exp_r.out_position) begin
                        $error("out_position exp %0d got %0d", exp_r.out_position,
                               o_out.out_position);
                        mismatch_count++;
                    end
                    if (o_out.heap_size !== exp_r.heap_size) begin
                        $error("heap_size exp %0d got %0d", exp_r.heap_size, o_out.heap_size);
                        mismatch_count++;
                    end
                    if (o_out.status !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, o_out.status);
                        mismatch_count++;
                    end
                end
                recv_wait = $urandom_range(0, 17);
                if ($urandom_range(0, 3) == 0) recv_wait = 0;
                // Long hold-off once, partway through, so the input backs up.
                if (!hold_off && result_queue.size() > 0 && op_queue.size() < 700) begin
                    hold_off = 1'b1;
                    recv_wait = 300;
                end
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on accepted transactions, and the end of the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        wait (stim_done && result_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && result_queue.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/imhdk_pkg.sv
hw/rtl/imhdk_ram.sv
hw/rtl/indexed_min_heap_decrease_key_core.sv
verif/indexed_min_heap_decrease_key_core_tb.sv
